@@ sv/aedc_pkg.sv @@
`default_nettype none

package aedc_pkg;

    // Filter accumulator and coefficient formats.
    localparam int ACC_W   = 40;
    localparam int ALPHA_W = 16;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd64881;

    // Audio result format and its stream word.
    localparam int OUT_W     = 17;
    localparam int OUT_MAX   = 65535;
    localparam int OUT_MIN   = -65536;
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQI,
        S_SQQ,
        S_ADD,
        S_SQRT,
        S_SUM,
        S_DIFF
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_status_t;

endpackage

`default_nettype wire

@@ sv/aedc_mul.sv @@
`default_nettype none

module aedc_mul #(
    parameter int A_W = 40,
    parameter int B_W = 16
) (
    input  wire logic               clk,
    input  wire logic [A_W-1:0]     a,
    input  wire logic [B_W-1:0]     b,
    output logic      [A_W+B_W-1:0] product
);

    logic [A_W+B_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
    end

    assign product = product_reg;

endmodule

`default_nettype wire

@@ sv/aedc_isqrt.sv @@
`default_nettype none

module aedc_isqrt #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [2*SAMPLE_WIDTH-1:0] radicand,
    output logic      [SAMPLE_WIDTH-1:0]   root,
    output aedc_pkg::sqrt_status_t         status
);

    localparam int X_W   = 2 * SAMPLE_WIDTH;
    localparam int CNT_W = $clog2(SAMPLE_WIDTH + 1);

    logic [X_W-1:0]   x_reg, x_next;
    logic [X_W-1:0]   root_reg, root_next;
    logic [X_W-1:0]   bit_reg, bit_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [X_W-1:0]   trial;

    // One result bit per cycle, starting from the top power of four.
    always_comb
    begin
        trial     = root_reg + bit_reg;
        x_next    = x_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = radicand;
            root_next = '0;
            bit_next  = X_W'(1) << (X_W - 2);
            cnt_next  = CNT_W'(SAMPLE_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (x_reg >= trial)
            begin
                x_next    = x_reg - trial;
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign root        = root_reg[SAMPLE_WIDTH-1:0];
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

@@ sv/am_envelope_dc_block.sv @@
// AM envelope detector with DC blocker. Each input item carries one complex
// sample (I in the low half of s_tdata, Q above it, block marker in s_tlast).
// The block forms the envelope as the truncated integer square root of
// I*I + Q*Q and passes it through a one-pole DC-removal filter whose pole is
// the pole coefficient register (unsigned Q0.16, reset 0.99), written over
// the cfg channel while the block is idle. One audio item leaves per input item,
// saturated to 17 bits, with the marker copied to m_tlast. Between acceptance
// and result each item passes through the square-root unit, which resolves
// one root bit per cycle, after the squares are formed and before the filter;
// a shared multiplier forms both squares and the filter product. The input
// side is not ready while an item is being worked on, and a finished result
// waits in the output register while the next item is already accepted.

`default_nettype none

module am_envelope_dc_block #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int FRAC_BITS    = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,

    // s_tdata fields from bit 0: i_sample, q_sample, zero fill.
    input  wire logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
    input  wire logic                                s_tlast,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,

    // m_tdata fields from bit 0: audio_sample, zero fill.
    output logic [aedc_pkg::M_TDATA_W-1:0]           m_tdata,
    output logic                                     m_tlast,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,

    input  wire logic [aedc_pkg::ALPHA_W-1:0]        cfg_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready
);

    localparam int SW      = SAMPLE_WIDTH;
    localparam int ACC_W   = aedc_pkg::ACC_W;
    localparam int ALPHA_W = aedc_pkg::ALPHA_W;
    localparam int OUT_W   = aedc_pkg::OUT_W;
    localparam int MB_W    = (SW > ALPHA_W) ? SW : ALPHA_W;
    localparam int P_W     = ACC_W + MB_W;
    localparam int MAG_W   = SW + FRAC_BITS;
    localparam int SUM_W   = ((MAG_W > ACC_W) ? MAG_W : ACC_W) + 1;
    localparam int DIFF_W  = ACC_W + 1;
    localparam logic signed [DIFF_W-1:0] OUT_MAX_D = DIFF_W'(aedc_pkg::OUT_MAX);
    localparam logic signed [DIFF_W-1:0] OUT_MIN_D = DIFF_W'(aedc_pkg::OUT_MIN);

    aedc_pkg::state_t state_reg, state_next;

    logic [ALPHA_W-1:0] alpha_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   z0_reg;
    logic [SW-1:0]      ia_reg, qa_reg;
    logic [2*SW-1:0]    sq_i_reg;
    logic               last_reg;
    logic [OUT_W-1:0]   audio_reg;
    logic               last_out_reg;
    logic               out_valid_reg, out_valid_next;

    logic [SW-1:0]      i_raw, q_raw;
    logic [ACC_W-1:0]   mul_a;
    logic [MB_W-1:0]    mul_b;
    logic [P_W-1:0]     product;
    logic               sqrt_start;
    logic [2*SW-1:0]    radicand;
    logic [SW-1:0]      mag;
    aedc_pkg::sqrt_status_t sq_status;
    logic               post;

    logic [ACC_W-1:0]         prod_alpha;
    logic [SUM_W-1:0]         sum_w;
    logic [ACC_W-1:0]         z0_sat;
    logic signed [DIFF_W-1:0] diff_w;
    logic signed [DIFF_W-1:0] diff_shr;
    logic [OUT_W-1:0]         audio_sat;

    assign i_raw = s_tdata[SW-1:0];
    assign q_raw = s_tdata[2*SW-1:SW];

    aedc_mul #(
        .A_W (ACC_W),
        .B_W (MB_W)
    ) u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    aedc_isqrt #(
        .SAMPLE_WIDTH (SW)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (radicand),
        .root     (mag),
        .status   (sq_status)
    );

    // The product of I squared is held while Q squared comes out.
    assign radicand = sq_i_reg + product[2*SW-1:0];

    assign prod_alpha = product[ACC_W+ALPHA_W-1:ALPHA_W];
    assign sum_w      = (SUM_W'(mag) << FRAC_BITS) + SUM_W'(prod_alpha);
    assign z0_sat     = (|sum_w[SUM_W-1:ACC_W]) ? {ACC_W{1'b1}} : sum_w[ACC_W-1:0];

    // The arithmetic shift gives the floor of the quotient for negative values.
    assign diff_w   = $signed({1'b0, z0_reg}) - $signed({1'b0, acc_reg});
    assign diff_shr = diff_w >>> FRAC_BITS;

    always_comb
    begin
        if (diff_shr > OUT_MAX_D)
        begin
            audio_sat = OUT_MAX_D[OUT_W-1:0];
        end
        else if (diff_shr < OUT_MIN_D)
        begin
            audio_sat = OUT_MIN_D[OUT_W-1:0];
        end
        else
        begin
            audio_sat = diff_shr[OUT_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        sqrt_start = 1'b0;
        post       = 1'b0;
        mul_a      = acc_reg;
        mul_b      = MB_W'(alpha_reg);
        unique case (state_reg)
            aedc_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = aedc_pkg::S_SQI;
                end
            end
            aedc_pkg::S_SQI:
            begin
                mul_a      = ACC_W'(ia_reg);
                mul_b      = MB_W'(ia_reg);
                state_next = aedc_pkg::S_SQQ;
            end
            aedc_pkg::S_SQQ:
            begin
                mul_a      = ACC_W'(qa_reg);
                mul_b      = MB_W'(qa_reg);
                state_next = aedc_pkg::S_ADD;
            end
            aedc_pkg::S_ADD:
            begin
                sqrt_start = 1'b1;
                state_next = aedc_pkg::S_SQRT;
            end
            aedc_pkg::S_SQRT:
            begin
                if (sq_status.done)
                begin
                    state_next = aedc_pkg::S_SUM;
                end
            end
            aedc_pkg::S_SUM:
            begin
                state_next = aedc_pkg::S_DIFF;
            end
            aedc_pkg::S_DIFF:
            begin
                post = !out_valid_reg || m_tready;
                if (post)
                begin
                    state_next = aedc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = aedc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (post)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aedc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            alpha_reg     <= aedc_pkg::ALPHA_RESET;
            acc_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                alpha_reg <= cfg_data;
            end
            if (post)
            begin
                acc_reg <= z0_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            ia_reg   <= i_raw[SW-1] ? (~i_raw + SW'(1)) : i_raw;
            qa_reg   <= q_raw[SW-1] ? (~q_raw + SW'(1)) : q_raw;
            last_reg <= s_tlast;
        end
        if (state_reg == aedc_pkg::S_SQQ)
        begin
            sq_i_reg <= product[2*SW-1:0];
        end
        if (state_reg == aedc_pkg::S_SUM)
        begin
            z0_reg <= z0_sat;
        end
        if (post)
        begin
            audio_reg    <= audio_sat;
            last_out_reg <= last_reg;
        end
    end

    // The coefficient only changes between items so that every item sees one value.
    assign cfg_ready = (state_reg == aedc_pkg::S_IDLE);
    assign m_tdata   = aedc_pkg::M_TDATA_W'(audio_reg);
    assign m_tlast   = last_out_reg;
    assign m_tvalid  = out_valid_reg;

    a_done_in_sqrt : assert property (@(posedge clk) disable iff (!rst_n)
        sq_status.done |-> state_reg == aedc_pkg::S_SQRT)
        else $error("square root finished outside its wait state");

    a_busy_in_sqrt : assert property (@(posedge clk) disable iff (!rst_n)
        sq_status.busy |-> state_reg == aedc_pkg::S_SQRT)
        else $error("square root running while the sequencer moved on");

    a_acc_on_post : assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(acc_reg) |-> $past(state_reg) == aedc_pkg::S_DIFF && m_tvalid)
        else $error("filter state changed without a result being posted");

endmodule

`default_nettype wire
